// ===== rtl/lrs_pkg.sv =====
// shared types, constants and sigmoid table for the logistic regression scorer
package lrs_pkg;

  localparam int MODEL_SIZE  = 256;
  localparam int STORE_DEPTH = 256;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int VAL_W       = 16;
  localparam int PROD_W      = 2 * VAL_W;
  localparam int SUM_W       = 48;
  localparam int SCORE_W     = 32;
  localparam int PROB_W      = 16;
  localparam int FRAC_BITS   = 20;
  localparam int FRAC_W      = FRAC_BITS;
  localparam int SEG_W       = 3;
  localparam int DF_W        = PROB_W + FRAC_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_FEATURE = 1'b1;

  localparam logic [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam logic [PROB_W:0]    PROB_ONE  = {1'b1, {PROB_W{1'b0}}};
  localparam logic [PROB_W-1:0]  PROB_HALF = {1'b1, {(PROB_W-1){1'b0}}};

  typedef struct packed {
    logic                    command;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } item_t;

  typedef struct packed {
    logic [PROB_W-1:0]         probability;
    logic signed [SCORE_W-1:0] score;
  } result_t;

  // classified request as it sits in the queue
  typedef struct packed {
    logic                    wr;
    logic                    acc;
    logic                    emit;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
  } op_t;

  // sigmoid at the integers 0..8, unsigned q0.16
  function automatic logic [PROB_W-1:0] sig_point(input logic [SEG_W:0] k);
    logic [PROB_W-1:0] p;
    case (k)
      4'd0:    p = 16'd32768;
      4'd1:    p = 16'd47911;
      4'd2:    p = 16'd57724;
      4'd3:    p = 16'd62428;
      4'd4:    p = 16'd64357;
      4'd5:    p = 16'd65097;
      4'd6:    p = 16'd65374;
      4'd7:    p = 16'd65476;
      default: p = 16'd65514;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/lrs_front.sv =====
// front end: request handshake and classification into queue operations
module lrs_front (
  input  logic              item_valid,
  output logic              item_stall,
  input  lrs_pkg::item_t    item,
  input  logic              full,
  output logic              push,
  output lrs_pkg::op_t      op
);

  logic in_model;

  always_comb begin
    in_model   = int'(item.index) < lrs_pkg::MODEL_SIZE;
    item_stall = full;
    push       = item_valid && !full;
    op.wr      = (item.command == lrs_pkg::CMD_WRITE) && in_model;
    op.acc     = (item.command == lrs_pkg::CMD_FEATURE) && in_model;
    // out-of-range features still close a descriptor
    op.emit    = (item.command == lrs_pkg::CMD_FEATURE) && item.last;
    op.index   = item.index;
    op.value   = item.value;
  end

endmodule

// ===== rtl/lrs_queue.sv =====
// short fifo of classified requests between front and back
module lrs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lrs_pkg::op_t  push_op,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output lrs_pkg::op_t  head
);

  lrs_pkg::op_t                 slots [lrs_pkg::QUEUE_DEPTH];
  logic [lrs_pkg::QPTR_W-1:0]   wr_ptr;
  logic [lrs_pkg::QPTR_W-1:0]   rd_ptr;
  logic [lrs_pkg::QCNT_W-1:0]   count;

  assign full  = count == lrs_pkg::QCNT_W'(lrs_pkg::QUEUE_DEPTH);
  assign valid = count != '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == lrs_pkg::QPTR_W'(lrs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == lrs_pkg::QPTR_W'(lrs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

// ===== rtl/lrs_back.sv =====
// back end: weight store, multiply-accumulate, sigmoid and result register
module lrs_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  lrs_pkg::op_t      q_op,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output lrs_pkg::result_t  result
);

  logic adv;

  logic signed [lrs_pkg::VAL_W-1:0] weights [lrs_pkg::STORE_DEPTH];

  // stage 1: weight read
  logic                             v1, acc1, emit1;
  logic signed [lrs_pkg::VAL_W-1:0] val1, rdata;
  // stage 2: product
  logic                              v2, acc2, emit2;
  logic signed [lrs_pkg::PROD_W-1:0] prod2;
  // stage 3: accumulator and closed sum
  logic [lrs_pkg::SUM_W-1:0]         sum;
  logic [lrs_pkg::SUM_W-1:0]         fin3;
  logic                              v3;
  logic [lrs_pkg::SUM_W:0]           sum_wide;
  logic [lrs_pkg::SUM_W-1:0]         sum_next;
  // stage 4: segment lookup
  logic                              v4, neg4;
  logic [lrs_pkg::PROB_W-1:0]        base4, d4;
  logic [lrs_pkg::FRAC_W-1:0]        f4;
  logic [lrs_pkg::SCORE_W-1:0]       score4;
  logic [lrs_pkg::SUM_W-1:0]         mag;
  logic                              ge8;
  logic [lrs_pkg::SEG_W-1:0]         seg;
  logic [lrs_pkg::SEG_W:0]           seg_lo, seg_hi;
  logic [lrs_pkg::SCORE_W-1:0]       score_sat;
  // stage 5: interpolation product
  logic                              v5, neg5;
  logic [lrs_pkg::PROB_W-1:0]        base5;
  logic [lrs_pkg::DF_W-1:0]          df5;
  logic [lrs_pkg::SCORE_W-1:0]       score5;
  logic [lrs_pkg::DF_W:0]            df_rnd;
  logic [lrs_pkg::PROB_W:0]          p_pos;
  logic [lrs_pkg::PROB_W:0]          p_full;

  // the whole back pipeline freezes while a result waits
  assign adv = !result_valid || !result_stall;
  assign pop = adv && q_valid;

  always_ff @(posedge clk) begin
    if (pop) begin
      if (q_op.wr) begin
        weights[q_op.index] <= q_op.value;
      end
      rdata <= weights[q_op.index];
    end
  end

  always_comb begin
    sum_wide = (lrs_pkg::SUM_W + 1)'(signed'(sum))
             + (lrs_pkg::SUM_W + 1)'(acc2 ? prod2 : lrs_pkg::PROD_W'(0));
    if (sum_wide[lrs_pkg::SUM_W] != sum_wide[lrs_pkg::SUM_W-1]) begin
      sum_next = sum_wide[lrs_pkg::SUM_W] ? lrs_pkg::SUM_MIN : lrs_pkg::SUM_MAX;
    end else begin
      sum_next = sum_wide[lrs_pkg::SUM_W-1:0];
    end
  end

  always_comb begin
    mag    = fin3[lrs_pkg::SUM_W-1] ? (lrs_pkg::SUM_W'(0) - fin3) : fin3;
    ge8    = |mag[lrs_pkg::SUM_W-1:lrs_pkg::FRAC_BITS+lrs_pkg::SEG_W];
    seg    = mag[lrs_pkg::FRAC_BITS+lrs_pkg::SEG_W-1:lrs_pkg::FRAC_BITS];
    seg_lo = {1'b0, seg};
    seg_hi = seg_lo + 1'b1;
    if ((&fin3[lrs_pkg::SUM_W-1:lrs_pkg::SCORE_W-1])
        || !(|fin3[lrs_pkg::SUM_W-1:lrs_pkg::SCORE_W-1])) begin
      score_sat = fin3[lrs_pkg::SCORE_W-1:0];
    end else begin
      score_sat = fin3[lrs_pkg::SUM_W-1] ? lrs_pkg::SCORE_MIN : lrs_pkg::SCORE_MAX;
    end
  end

  always_comb begin
    df_rnd = (lrs_pkg::DF_W + 1)'(df5)
           + ((lrs_pkg::DF_W + 1)'(1) << (lrs_pkg::FRAC_BITS - 1));
    p_pos  = (lrs_pkg::PROB_W + 1)'(base5)
           + df_rnd[lrs_pkg::DF_W:lrs_pkg::FRAC_BITS];
    p_full = neg5 ? (lrs_pkg::PROB_ONE - p_pos) : p_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      v5           <= 1'b0;
      sum          <= '0;
      result_valid <= 1'b0;
    end else if (adv) begin
      v1           <= pop && (q_op.acc || q_op.emit);
      v2           <= v1;
      v3           <= v2 && emit2;
      v4           <= v3;
      v5           <= v4;
      result_valid <= v5;
      if (v2) begin
        sum <= emit2 ? '0 : sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc1  <= q_op.acc;
      emit1 <= q_op.emit;
      val1  <= q_op.value;

      acc2  <= acc1;
      emit2 <= emit1;
      prod2 <= lrs_pkg::PROD_W'(val1) * lrs_pkg::PROD_W'(rdata);

      fin3  <= sum_next;

      neg4   <= fin3[lrs_pkg::SUM_W-1];
      f4     <= mag[lrs_pkg::FRAC_W-1:0];
      score4 <= score_sat;
      if (ge8) begin
        base4 <= lrs_pkg::sig_point(4'd8);
        d4    <= '0;
      end else begin
        base4 <= lrs_pkg::sig_point(seg_lo);
        d4    <= lrs_pkg::sig_point(seg_hi) - lrs_pkg::sig_point(seg_lo);
      end

      neg5   <= neg4;
      base5  <= base4;
      score5 <= score4;
      df5    <= lrs_pkg::DF_W'(d4) * lrs_pkg::DF_W'(f4);

      result.probability <= p_full[lrs_pkg::PROB_W-1:0];
      result.score       <= score5;
    end
  end

endmodule

// ===== rtl/logistic_regression_scorer.sv =====
// logistic regression scorer: weight store, dot product and sigmoid output
//
// requests enter on item / item_valid / item_stall. command write stores a
// q4.12 weight at index; command feature multiplies a q8.8 element by the
// stored weight and adds it to the running sum. a feature with last set
// closes the descriptor: one result leaves on result / result_valid /
// result_stall with the q12.20 sum saturated to 32 bits and its q0.16
// sigmoid, and the sum clears. write requests and other features give none.
// throughput is one request per cycle while item_stall is low; the
// accumulate register carries the loop from one element to the next.
// a closing feature passes through the four-entry queue, then the five back
// stages (weight read, multiply, accumulate, table lookup, interpolation) and
// the result register before it shows result_valid. reset empties the queue
// and pipeline and clears the sum; weights are undefined until written. while
// result_stall holds a result, the back pipeline freezes, the queue fills and
// item_stall rises.
module logistic_regression_scorer (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  lrs_pkg::item_t     item,
  output logic               result_valid,
  input  logic               result_stall,
  output lrs_pkg::result_t   result
);

  logic          full;
  logic          push;
  lrs_pkg::op_t  push_op;
  logic          pop;
  logic          q_valid;
  lrs_pkg::op_t  q_op;

  lrs_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .full       (full),
    .push       (push),
    .op         (push_op)
  );

  lrs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (pop),
    .valid   (q_valid),
    .head    (q_op)
  );

  lrs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_op         (q_op),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // nothing leaves the queue while a result is held
  a_hold_freezes: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> !pop)
    else $error("queue popped while result stalled");

  // sigmoid sits on the same side of one half as the score
  a_prob_pos: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.score[lrs_pkg::SCORE_W-1]
      |-> result.probability >= lrs_pkg::PROB_HALF)
    else $error("probability below half for non-negative score");

  a_prob_neg: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.score[lrs_pkg::SCORE_W-1]
      |-> result.probability <= lrs_pkg::PROB_HALF)
    else $error("probability above half for negative score");

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the logistic regression scorer
`timescale 1ns / 1ps

module testbench;
  import lrs_pkg::*;

  localparam int     RANDOM_ITEMS = 850;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     DRAIN_TAIL   = 24;
  localparam int     CYCLE_LIMIT  = 200_000;
  localparam longint ACC_MAX      = (longint'(1) << (SUM_W - 1)) - 1;
  localparam longint ACC_MIN      = -(longint'(1) << (SUM_W - 1));
  localparam longint SCORE_HI     = (longint'(1) << (SCORE_W - 1)) - 1;
  localparam longint SCORE_LO     = -(longint'(1) << (SCORE_W - 1));
  // logistic curve at x = 0..8 in q0.16
  localparam longint SIG_AT [0:8] = '{32768, 47911, 57724, 62428, 64357,
                                      65097, 65374, 65476, 65514};

  // mirrors the weight store and running sum, queues expected scores
  class lr_scoreboard;
    logic signed [VAL_W-1:0] weight_copy [STORE_DEPTH];
    longint                  dot_acc;
    result_t                 expected_scores [$];
    int unsigned             failures;

    function new();
      dot_acc  = 0;
      failures = 0;
      foreach (weight_copy[i]) weight_copy[i] = '0;
    endfunction

    function void note_request(input item_t req);
      longint  prod;
      longint  mag;
      longint  frac;
      longint  slope;
      longint  prob;
      longint  clipped;
      int      k;
      result_t want;
      if (req.command == CMD_WRITE) begin
        if (int'(req.index) < MODEL_SIZE) weight_copy[req.index] = req.value;
        return;
      end
      if (int'(req.index) < MODEL_SIZE) begin
        prod = longint'($signed(req.value)) * longint'($signed(weight_copy[req.index]));
        dot_acc = dot_acc + prod;
        if (dot_acc > ACC_MAX) dot_acc = ACC_MAX;
        else if (dot_acc < ACC_MIN) dot_acc = ACC_MIN;
      end
      if (!req.last) return;
      mag = (dot_acc < 0) ? -dot_acc : dot_acc;
      if (mag >= (longint'(8) << FRAC_BITS)) begin
        prob = SIG_AT[8];
      end else begin
        k     = int'(mag >>> FRAC_BITS);
        frac  = mag & ((longint'(1) << FRAC_BITS) - 1);
        slope = SIG_AT[k + 1] - SIG_AT[k];
        prob  = SIG_AT[k] + ((slope * frac + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS);
      end
      // negative side mirrors about one half
      if (dot_acc < 0) prob = 65536 - prob;
      clipped = dot_acc;
      if (clipped > SCORE_HI) clipped = SCORE_HI;
      else if (clipped < SCORE_LO) clipped = SCORE_LO;
      want.probability = prob[PROB_W-1:0];
      want.score       = clipped[SCORE_W-1:0];
      expected_scores = {expected_scores, want};
      dot_acc = 0;
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (expected_scores.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: probability %0d score %0d",
                   got.probability, got.score);
        return;
      end
      want = expected_scores.pop_front();
      if (got.probability !== want.probability || got.score !== want.score) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: probability exp %0d got %0d, score exp %0d got %0d",
                   want.probability, got.probability, want.score, got.score);
      end
    endfunction
  endclass

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  lr_scoreboard sb = new();

  bit          weight_set [STORE_DEPTH];
  bit          hold_request = 1'b0;
  int unsigned burst_left   = 0;
  int unsigned sent_count   = 0;

  logistic_regression_scorer i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_request(input logic cmd, input logic [IDX_W-1:0] idx,
                              input logic signed [VAL_W-1:0] val, input logic lst);
    item_t req;
    req.command = cmd;
    req.index   = idx;
    req.value   = val;
    req.last    = lst;
    if (cmd == CMD_WRITE) weight_set[idx] = 1'b1;
    item       <= req;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    sb.note_request(req);
    sent_count++;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // a weight must be in the store before any feature reads it
  task automatic send_feature(input logic [IDX_W-1:0] idx,
                              input logic signed [VAL_W-1:0] val, input logic lst);
    if (!weight_set[idx])
      send_request(CMD_WRITE, idx, pick_value(4096), 1'($urandom_range(0, 1)));
    send_request(CMD_FEATURE, idx, val, lst);
  endtask

  task automatic wait_drained();
    while (sb.expected_scores.size() != 0) @(negedge clk);
  endtask

  // mag is one unit in the field's fixed-point format
  function automatic logic signed [VAL_W-1:0] pick_value(input int mag);
    int v;
    case ($urandom_range(0, 9))
      0:       v = -32768;
      1:       v = 32767;
      2:       v = 0;
      3, 4, 5: v = int'($signed(16'($urandom)));
      default: v = int'($urandom_range(0, 2 * mag)) - mag;
    endcase
    return v[VAL_W-1:0];
  endfunction

  initial begin : stimulus
    int unsigned roll;
    int unsigned len;
    bit          hold_done;
    hold_done = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part
    send_request(CMD_WRITE, 8'd0, -16'sd32768, 1'b1);   // last on a write is ignored
    send_request(CMD_WRITE, 8'd255, 16'sd32767, 1'b0);
    send_request(CMD_WRITE, 8'd1, 16'sd4096, 1'b0);
    send_request(CMD_WRITE, 8'd2, 16'sd0, 1'b1);
    send_request(CMD_FEATURE, 8'd2, 16'sd32767, 1'b1);  // zero sum
    send_request(CMD_FEATURE, 8'd0, -16'sd32768, 1'b1); // positive tail
    send_request(CMD_FEATURE, 8'd0, -16'sd32768, 1'b0);
    send_request(CMD_FEATURE, 8'd0, -16'sd32768, 1'b1); // score clips high
    send_request(CMD_FEATURE, 8'd0, 16'sd32767, 1'b0);
    send_request(CMD_FEATURE, 8'd0, 16'sd32767, 1'b0);
    send_request(CMD_FEATURE, 8'd0, 16'sd32767, 1'b1);  // score clips low
    send_request(CMD_FEATURE, 8'd1, 16'sd256, 1'b1);    // exactly one
    send_request(CMD_FEATURE, 8'd1, -16'sd384, 1'b1);   // between table points, negative
    send_request(CMD_FEATURE, 8'd1, 16'sd2047, 1'b1);   // just below the tail
    send_request(CMD_FEATURE, 8'd1, 16'sd2048, 1'b1);   // exactly eight
    send_request(CMD_FEATURE, 8'd1, -16'sd2048, 1'b1);  // negative tail
    send_request(CMD_FEATURE, 8'd255, -16'sd32768, 1'b1);
    send_request(CMD_FEATURE, 8'd255, 16'sd1, 1'b0);
    send_request(CMD_FEATURE, 8'd1, -16'sd1, 1'b1);
    item_valid <= 1'b0;
    wait_drained();

    // random part
    sent_count = 0;
    while (sent_count < RANDOM_ITEMS) begin
      if (sent_count > 300 && !hold_done) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        send_request(CMD_WRITE, 8'($urandom), pick_value(4096), 1'($urandom_range(0, 1)));
      end else if (roll < 17) begin
        send_feature(8'($urandom), pick_value(256), 1'($urandom_range(0, 1)));
      end else if (roll < 20) begin
        item_valid <= 1'b0;
        wait_drained();
      end else begin
        len = $urandom_range(1, 8);
        for (int unsigned i = 0; i < len; i++)
          send_feature(8'($urandom), pick_value(256), i == len - 1);
      end
    end
    item_valid <= 1'b0;

    while (sb.expected_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    sb.failures += sb.expected_scores.size();
    if (sb.failures == 0)
      $display("[logistic_regression_scorer] OK");
    else
      $display("[logistic_regression_scorer] ERROR");
    $finish;
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin : result_side
    int unsigned mode;
    int unsigned mode_left;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0:       result_stall <= 1'b0;
          1:       result_stall <= 1'($urandom_range(0, 1));
          2:       result_stall <= ($urandom_range(0, 3) != 0);
          default: result_stall <= mode_left[1];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[logistic_regression_scorer] ERROR");
    $finish;
  end

endmodule
